/* hdl/mpe_channel_allocator_defines.svh */
// assertion macros for the channel allocator
`ifndef MPE_CHANNEL_ALLOCATOR_DEFINES_SVH
`define MPE_CHANNEL_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// property checked on clk_i, off while rst_ni is low
`define MCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// same with an explicit clock and reset
`define MCA_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`else
`define MCA_ASSERT(lbl, prop, msg)
`define MCA_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`endif

`endif

/* hdl/mca_pkg.sv */
`default_nettype none
package mca_pkg;

  localparam int unsigned SPAN_W   = 7;
  localparam int unsigned TBL_W    = 21;
  localparam int unsigned SEMI_W   = 27;
  localparam int unsigned ABSD_W   = 25;
  localparam int unsigned MAG_W    = 39;
  localparam int unsigned NUM_W    = 23;
  localparam int unsigned BEND_W   = 14;

  localparam logic [SPAN_W-1:0] SPAN_RST = 7'd48;
  localparam logic [SPAN_W-1:0] SPAN_MAX = 7'd96;

  // log2(middle c) in q5.16 and 60 semitones in q.16
  localparam logic signed [SEMI_W-1:0] C4_Q16     = 27'sd526343;
  localparam logic signed [SEMI_W-1:0] SEMI60_Q16 = 27'sd3932160;
  localparam logic signed [SEMI_W-1:0] HALF_Q16   = 27'sd32768;

  localparam logic [NUM_W-1:0]  BEND_MID_Q = 23'd8192;
  localparam logic [NUM_W-1:0]  BEND_POS_Q = 23'd8191;
  localparam logic [BEND_W-1:0] BEND_MID   = 14'd8192;
  localparam logic [BEND_W-1:0] BEND_MAX   = 14'd16383;
  localparam logic [6:0]        NOTE_MAX   = 7'd127;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_BEND     = 4'hE;

  localparam logic [1:0] LEN_FULL = 2'd3;

  typedef enum logic [1:0] {
    CMD_MIDI   = 2'd0,
    CMD_TBL_WR = 2'd1,
    CMD_RETUNE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage
`default_nettype wire

/* hdl/mca_div.sv */
`default_nettype none
// restoring divider, one quotient bit per cycle
module mca_div import mca_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [SPAN_W-1:0] den_i,
  output div_stat_t              stat_o,
  output logic      [NUM_W-1:0]  quot_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  acc_q;
  logic [SPAN_W-1:0] rem_q;
  logic [SPAN_W-1:0] den_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [SPAN_W:0]   trial;
  logic              ge;
  logic [SPAN_W:0]   diff;

  always_comb begin
    trial = {rem_q, acc_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = acc_q;

endmodule
`default_nettype wire

/* hdl/mpe_channel_allocator.sv */
`default_nettype none
// mpe channel allocator: spreads incoming midi notes over NUM_CHANNELS channels from
// FIRST_CHANNEL up, taking the least recently used voice and stealing it with a note-off
// when it still sounds. each note is retuned from a 128-entry table of log2 frequencies
// (q5.16): the block emits a pitch bend and then the note-on on the nearest 12-tet note.
// the tuning table is not cleared at reset and must be written before a note reads it.
// one input word is handled at a time and in_stall_o stays high until its work is done.
// the work is a voice scan (one voice per cycle), an order-stack scan (one entry per
// cycle) and a restoring divider for the bend: a note-on runs the voice scan, the bend
// datapath with the divider and the order-stack scan, a retune runs the bend datapath for
// each sounding voice, a tick steps through the voices. results leave through an output
// register, so the next word is accepted while the last result still waits.
module mpe_channel_allocator import mca_pkg::*; #(
  parameter int unsigned NUM_CHANNELS  = 15,
  parameter int unsigned FIRST_CHANNEL = 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: bend span in semitones
  input  wire logic              cfg_we_i,
  input  wire logic [SPAN_W-1:0] cfg_wdata_i,
  // input words
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [1:0]        cmd_i,
  input  wire logic [7:0]        status_byte_i,
  input  wire logic [7:0]        data1_i,
  input  wire logic [7:0]        data2_i,
  input  wire logic [1:0]        msg_len_i,
  input  wire logic [6:0]        table_index_i,
  input  wire logic [TBL_W-1:0]  table_value_i,
  // output words
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [7:0]             out_byte0_o,
  output logic [7:0]             out_byte1_o,
  output logic [7:0]             out_byte2_o,
  output logic [1:0]             out_length_o,
  output logic                   last_o
);

`include "mpe_channel_allocator_defines.svh"

  localparam int unsigned VW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [VW-1:0] LAST_V = VW'(NUM_CHANNELS - 1);

  typedef enum logic [18:0] {
    S_IDLE  = 19'h00001,
    S_FIND  = 19'h00002,
    S_EXOFF = 19'h00004,
    S_STEAL = 19'h00008,
    S_TRD   = 19'h00010,
    S_SEMI  = 19'h00020,
    S_NOTE  = 19'h00040,
    S_MAG1  = 19'h00080,
    S_MAG2  = 19'h00100,
    S_DIV   = 19'h00200,
    S_BEND  = 19'h00400,
    S_EMB   = 19'h00800,
    S_EMN   = 19'h01000,
    S_PASS  = 19'h02000,
    S_FOFF  = 19'h04000,
    S_RT    = 19'h08000,
    S_TK    = 19'h10000,
    S_OSCAN = 19'h20000,
    S_OAPP  = 19'h40000
  } state_e;

  state_e state_q, state_d, ret_q;

  // configuration
  logic [SPAN_W-1:0] span_q;

  // latched word
  logic [7:0] st_q, note_q, vel_q;
  logic [1:0] len_q;
  logic       onpath_q;

  // voice state
  logic [NUM_CHANNELS-1:0] active_q;
  logic [7:0]              src_q  [NUM_CHANNELS];
  logic [6:0]              snd_q  [NUM_CHANNELS];
  logic [BEND_W-1:0]       bend_q [NUM_CHANNELS];
  logic [VW-1:0]           order_q [NUM_CHANNELS];
  logic                    due_q;

  // tuning table
  logic [TBL_W-1:0] tbl_mem [128];
  logic [TBL_W-1:0] tdata_q;
  logic [6:0]       taddr;

  // sequencer registers
  logic [VW-1:0] vidx_q;
  logic [VW-1:0] j_q, ov_q, r_q, p_q;
  logic          rf_q, pf_q, top_q;

  // bend datapath
  logic signed [SEMI_W-1:0] s_q;
  logic [6:0]               nn_q;
  logic                     neg_q;
  logic [ABSD_W-1:0]        absd_q;
  logic [MAG_W-1:0]         m_q;

  // divider
  logic              div_start;
  logic [NUM_W-1:0]  div_num;
  logic [NUM_W-1:0]  div_quot;
  div_stat_t         div_stat;

  // output register
  logic       out_valid_q;
  logic [7:0] ob0_q, ob1_q, ob2_q;
  logic [1:0] olen_q;
  logic       olast_q;

  logic       free;
  logic       emit;
  logic [7:0] e0, e1, e2;
  logic       elast;

  logic [7:0] in_note, in_vel;
  logic [3:0] in_type;
  logic       accept;

  logic               match;
  logic [VW-1:0]      cur_ord;
  logic               more_act;
  logic [6:0]         nn_calc;
  logic [10:0]        rnd_hi;
  logic signed [SEMI_W-1:0] rnd, delta, sx;
  logic [MAG_W-1:0]   mag_sum;
  logic [BEND_W-1:0]  bend_new;
  logic [VW-1:0]      pos;
  logic [VW-1:0]      lp [NUM_CHANNELS];
  logic [VW-1:0]      ord_new [NUM_CHANNELS];

  function automatic logic [3:0] chan_of(input logic [VW-1:0] v);
    chan_of = 4'(FIRST_CHANNEL - 1) + 4'(v);
  endfunction

  // input decode
  assign in_note  = (msg_len_i >= 2'd2) ? data1_i : 8'd0;
  assign in_vel   = (msg_len_i >= 2'd3) ? data2_i : 8'd0;
  assign in_type  = status_byte_i[7:4];
  assign in_stall_o = (state_q != S_IDLE);
  assign accept   = in_valid_i && !in_stall_o;

  assign free = !out_valid_q || !out_stall_i;

  assign match   = active_q[vidx_q] && (src_q[vidx_q] == note_q);
  assign cur_ord = order_q[j_q];

  // any sounding voice above the current one, for the tick's last flag
  always_comb begin
    more_act = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (VW'(i) > vidx_q && active_q[i]) more_act = 1'b1;
    end
  end

  // table read address
  assign taddr = onpath_q ? note_q[6:0] : src_q[vidx_q][6:0];

  // semitones q.16: (t - c4) * 12 + 60
  always_comb begin
    sx = $signed({{(SEMI_W-TBL_W){1'b0}}, tdata_q}) - C4_Q16;
  end

  // nearest note, rounded half away, clamped
  always_comb begin
    rnd    = s_q + HALF_Q16;
    rnd_hi = rnd[26:16];
    if (s_q < 0)                    nn_calc = 7'd0;
    else if (rnd_hi > 11'(NOTE_MAX)) nn_calc = NOTE_MAX;
    else                            nn_calc = rnd_hi[6:0];
  end

  always_comb begin
    delta = s_q - $signed({4'd0, (onpath_q ? nn_calc : snd_q[vidx_q]), 16'd0});
  end

  // |delta| * 8191 + span/2 in q.16, the divide by span is left
  assign mag_sum = m_q + (MAG_W'(span_q) << 15);
  assign div_num = mag_sum[MAG_W-1:16];
  assign div_start = (state_q == S_MAG2);

  // bend = 8192 +/- quotient, saturated
  always_comb begin
    if (neg_q) begin
      bend_new = (div_quot > BEND_MID_Q) ? '0 : BEND_MID - div_quot[BEND_W-1:0];
    end else begin
      bend_new = (div_quot > BEND_POS_Q) ? BEND_MAX : BEND_MID + div_quot[BEND_W-1:0];
    end
  end

  // order stack rewrite: remove ov at r, insert at pos
  always_comb begin
    if (top_q || !pf_q)  pos = LAST_V;
    else if (p_q < r_q)  pos = p_q;
    else                 pos = p_q - 1'b1;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (VW'(k) < r_q) lp[k] = order_q[k];
      else              lp[k] = order_q[(k == NUM_CHANNELS - 1) ? k : k + 1];
    end
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (VW'(k) < pos)       ord_new[k] = lp[k];
      else if (VW'(k) == pos) ord_new[k] = ov_q;
      else                    ord_new[k] = lp[(k == 0) ? 0 : k - 1];
    end
  end

  // sequencer next state and result words
  always_comb begin
    state_d = state_q;
    emit    = 1'b0;
    e0      = '0;
    e1      = '0;
    e2      = '0;
    elast   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_MIDI: begin
              if (msg_len_i == 2'd0) state_d = S_IDLE;
              else if (in_type == MSG_NOTE_ON || in_type == MSG_NOTE_OFF) state_d = S_FIND;
              else state_d = S_PASS;
            end
            CMD_TBL_WR, CMD_RETUNE: state_d = S_RT;
            CMD_TICK: state_d = due_q ? S_TK : S_IDLE;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIND: begin
        if (match) state_d = onpath_q ? S_EXOFF : S_FOFF;
        else if (vidx_q == LAST_V) state_d = onpath_q ? S_STEAL : S_PASS;
      end
      S_EXOFF: begin
        if (free) begin
          emit    = 1'b1;
          e0      = {MSG_NOTE_OFF, chan_of(vidx_q)};
          e1      = {1'b0, snd_q[vidx_q]};
          state_d = S_OSCAN;
        end
      end
      S_STEAL: begin
        if (active_q[order_q[0]]) begin
          if (free) begin
            emit    = 1'b1;
            e0      = {MSG_NOTE_OFF, chan_of(order_q[0])};
            e1      = {1'b0, snd_q[order_q[0]]};
            state_d = S_TRD;
          end
        end else begin
          state_d = S_TRD;
        end
      end
      S_TRD:  state_d = S_SEMI;
      S_SEMI: state_d = S_NOTE;
      S_NOTE: state_d = S_MAG1;
      S_MAG1: state_d = S_MAG2;
      S_MAG2: state_d = S_DIV;
      S_DIV:  if (div_stat.done) state_d = S_BEND;
      S_BEND: begin
        if (onpath_q) state_d = S_OSCAN;
        else if (vidx_q == LAST_V) state_d = S_IDLE;
        else state_d = S_RT;
      end
      S_EMB: begin
        if (free) begin
          emit    = 1'b1;
          e0      = {MSG_BEND, chan_of(vidx_q)};
          e1      = {1'b0, bend_q[vidx_q][6:0]};
          e2      = {1'b0, bend_q[vidx_q][13:7]};
          state_d = S_EMN;
        end
      end
      S_EMN: begin
        if (free) begin
          emit    = 1'b1;
          e0      = {MSG_NOTE_ON, chan_of(vidx_q)};
          e1      = {1'b0, snd_q[vidx_q]};
          e2      = vel_q;
          elast   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_PASS: begin
        if (free) begin
          emit    = 1'b1;
          e0      = st_q;
          e1      = note_q;
          e2      = vel_q;
          elast   = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_FOFF: begin
        if (free) begin
          emit    = 1'b1;
          e0      = {MSG_NOTE_OFF, chan_of(vidx_q)};
          e1      = {1'b0, snd_q[vidx_q]};
          e2      = vel_q;
          elast   = 1'b1;
          state_d = S_OSCAN;
        end
      end
      S_RT: begin
        if (active_q[vidx_q]) state_d = S_TRD;
        else if (vidx_q == LAST_V) state_d = S_IDLE;
      end
      S_TK: begin
        if (active_q[vidx_q]) begin
          if (free) begin
            emit  = 1'b1;
            e0    = {MSG_BEND, chan_of(vidx_q)};
            e1    = {1'b0, bend_q[vidx_q][6:0]};
            e2    = {1'b0, bend_q[vidx_q][13:7]};
            elast = !more_act;
            if (vidx_q == LAST_V) state_d = S_IDLE;
          end
        end else if (vidx_q == LAST_V) begin
          state_d = S_IDLE;
        end
      end
      S_OSCAN: if (j_q == LAST_V) state_d = S_OAPP;
      S_OAPP:  state_d = ret_q;
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      span_q      <= SPAN_RST;
      active_q    <= '0;
      due_q       <= 1'b0;
      out_valid_q <= 1'b0;
      vidx_q      <= '0;
      j_q         <= '0;
      rf_q        <= 1'b0;
      pf_q        <= 1'b0;
      top_q       <= 1'b0;
      onpath_q    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) order_q[i] <= VW'(i);
    end else begin
      state_q <= state_d;

      if (cfg_we_i && cfg_wdata_i != '0 && cfg_wdata_i <= SPAN_MAX) span_q <= cfg_wdata_i;

      if (emit)             out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            vidx_q   <= '0;
            onpath_q <= (cmd_e'(cmd_i) == CMD_MIDI) && (in_type == MSG_NOTE_ON) &&
                        (in_vel != 8'd0);
            case (cmd_e'(cmd_i))
              CMD_TBL_WR, CMD_RETUNE: due_q <= 1'b1;
              CMD_TICK: due_q <= 1'b0;
              default: ;
            endcase
          end
        end
        S_FIND: begin
          if (!match && vidx_q != LAST_V) vidx_q <= vidx_q + 1'b1;
        end
        S_EXOFF: begin
          if (free) begin
            active_q[vidx_q] <= 1'b0;
            ov_q  <= vidx_q;
            top_q <= 1'b0;
            j_q   <= '0;
            rf_q  <= 1'b0;
            pf_q  <= 1'b0;
            ret_q <= S_STEAL;
          end
        end
        S_STEAL: begin
          if (active_q[order_q[0]]) begin
            if (free) begin
              active_q[order_q[0]] <= 1'b0;
              vidx_q <= order_q[0];
            end
          end else begin
            vidx_q <= order_q[0];
          end
        end
        S_BEND: begin
          if (onpath_q) begin
            active_q[vidx_q] <= 1'b1;
            ov_q  <= vidx_q;
            top_q <= 1'b1;
            j_q   <= '0;
            rf_q  <= 1'b0;
            pf_q  <= 1'b0;
            ret_q <= S_EMB;
          end else if (vidx_q != LAST_V) begin
            vidx_q <= vidx_q + 1'b1;
          end
        end
        S_FOFF: begin
          if (free) begin
            active_q[vidx_q] <= 1'b0;
            ov_q  <= vidx_q;
            top_q <= 1'b0;
            j_q   <= '0;
            rf_q  <= 1'b0;
            pf_q  <= 1'b0;
            ret_q <= S_IDLE;
          end
        end
        S_RT: begin
          if (!active_q[vidx_q] && vidx_q != LAST_V) vidx_q <= vidx_q + 1'b1;
        end
        S_TK: begin
          if ((!active_q[vidx_q] || free) && vidx_q != LAST_V) vidx_q <= vidx_q + 1'b1;
        end
        S_OSCAN: begin
          if (cur_ord == ov_q) rf_q <= 1'b1;
          if (!pf_q && active_q[cur_ord]) pf_q <= 1'b1;
          if (j_q != LAST_V) j_q <= j_q + 1'b1;
        end
        S_OAPP: begin
          for (int k = 0; k < NUM_CHANNELS; k++) order_q[k] <= ord_new[k];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q   <= status_byte_i;
      note_q <= in_note;
      vel_q  <= in_vel;
      len_q  <= msg_len_i;
    end
    if (emit) begin
      ob0_q   <= e0;
      ob1_q   <= e1;
      ob2_q   <= e2;
      olen_q  <= (state_q == S_PASS) ? len_q : LEN_FULL;
      olast_q <= elast;
    end
    if (state_q == S_OSCAN) begin
      if (cur_ord == ov_q) r_q <= j_q;
      if (!pf_q && active_q[cur_ord]) p_q <= j_q;
    end
    if (state_q == S_SEMI) s_q <= (sx <<< 3) + (sx <<< 2) + SEMI60_Q16;
    if (state_q == S_NOTE) begin
      nn_q   <= onpath_q ? nn_calc : snd_q[vidx_q];
      neg_q  <= delta < 0;
      absd_q <= (delta < 0) ? ABSD_W'(-delta) : ABSD_W'(delta);
    end
    // |delta| * 8191 as shift and subtract
    if (state_q == S_MAG1) m_q <= (MAG_W'(absd_q) << 13) - MAG_W'(absd_q);
    if (state_q == S_BEND) begin
      bend_q[vidx_q] <= bend_new;
      if (onpath_q) begin
        src_q[vidx_q] <= note_q;
        snd_q[vidx_q] <= nn_q;
      end
    end
  end

  // tuning table memory
  always_ff @(posedge clk_i) begin
    if (accept && cmd_e'(cmd_i) == CMD_TBL_WR) tbl_mem[table_index_i] <= table_value_i;
    if (state_q == S_TRD) tdata_q <= tbl_mem[taddr];
  end

  mca_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span_q),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign out_valid_o  = out_valid_q;
  assign out_byte0_o  = ob0_q;
  assign out_byte1_o  = ob1_q;
  assign out_byte2_o  = ob2_q;
  assign out_length_o = olen_q;
  assign last_o       = olast_q;

  // the divider only finishes while the sequencer waits for it
  `MCA_ASSERT(a_div_done_in_wait, div_stat.done |-> state_q == S_DIV, "divider done outside wait")
  // the voice being moved must have been found in the order stack
  `MCA_ASSERT(a_order_found, state_q == S_OAPP |-> rf_q, "voice missing from order stack")
  // the oldest order entry names a real voice whenever a steal looks at it
  `MCA_ASSERT(a_order_range, state_q == S_STEAL |-> order_q[0] <= LAST_V, "order entry out of range")

endmodule
`default_nettype wire

/* bench/tb.sv */
`default_nettype none
module tb;
  import mca_pkg::*;

  localparam int NCH = 15;
  localparam int CYCLE_LIMIT = 3000000;
  // longest quiet stretch of the block on a word that yields nothing (retune of 15 voices)
  localparam int SETTLE = 700;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] len;
    logic       last;
  } midi_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [SPAN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  cmd_e cmd = CMD_MIDI;
  logic [7:0] status_byte = '0, data1 = '0, data2 = '0;
  logic [1:0] msg_len = '0;
  logic [6:0] table_index = '0;
  logic [TBL_W-1:0] table_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_b0, out_b1, out_b2;
  logic [1:0] out_len;
  logic out_last;

  mpe_channel_allocator dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .status_byte_i(status_byte), .data1_i(data1), .data2_i(data2),
    .msg_len_i(msg_len), .table_index_i(table_index), .table_value_i(table_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_byte0_o(out_b0), .out_byte1_o(out_b1), .out_byte2_o(out_b2),
    .out_length_o(out_len), .last_o(out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- voice model
  logic              voice_on[NCH];
  logic [7:0]        voice_src[NCH];
  logic [6:0]        voice_snd[NCH];
  logic [BEND_W-1:0] voice_bend[NCH];
  int                lru_stack[NCH];      // voice indices, least recently used first
  logic [TBL_W-1:0]  tuning[128];
  bit                tuning_written[128];
  bit                bend_refresh;
  logic [SPAN_W-1:0] span;

  midi_word_t expected_words[$];
  int errors = 0;
  int words_sent = 0;
  int words_seen = 0;
  int steals = 0;
  int cycles = 0;

  // stimulus shaping, changed per phase
  int send_idle_pct = 0;
  int stall_pct = 0;

  function automatic longint round_half_away(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (2 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  // pitch in semitones, q.16, from the tuning entry of the note
  function automatic longint pitch_q16(logic [7:0] note);
    return (longint'(tuning[note[6:0]]) - 526343) * 12 + 60 * 65536;
  endfunction

  function automatic logic [BEND_W-1:0] bend_of(longint s, logic [6:0] snd);
    longint b;
    b = 8192 + round_half_away((s - longint'(snd) * 65536) * 8191, 65536 * longint'(span));
    if (b < 0) b = 0;
    if (b > 16383) b = 16383;
    return b[BEND_W-1:0];
  endfunction

  function automatic logic [3:0] chan_of(int v);
    return 4'(v + 1);   // first channel is 2 (1-based), so voice v sits on nibble v+1
  endfunction

  function automatic int voice_of(logic [7:0] note);
    for (int i = 0; i < NCH; i++)
      if (voice_on[i] && voice_src[i] == note) return i;
    return -1;
  endfunction

  function automatic void lru_pull(int v);
    for (int i = 0; i < NCH; i++)
      if (lru_stack[i] == v) begin
        for (int j = i; j < NCH - 1; j++) lru_stack[j] = lru_stack[j + 1];
        return;
      end
  endfunction

  // freed voice goes just below the oldest sounding voice
  function automatic void lru_free(int v);
    int pos;
    pos = NCH - 1;
    lru_pull(v);
    for (int i = 0; i < NCH - 1; i++)
      if (voice_on[lru_stack[i]]) begin
        pos = i;
        break;
      end
    for (int i = NCH - 1; i > pos; i--) lru_stack[i] = lru_stack[i - 1];
    lru_stack[pos] = v;
  endfunction

  function automatic void retune_voices();
    for (int i = 0; i < NCH; i++)
      if (voice_on[i]) voice_bend[i] = bend_of(pitch_q16(voice_src[i]), voice_snd[i]);
    bend_refresh = 1'b1;
  endfunction

  function automatic midi_word_t mk(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                    logic [1:0] len);
    midi_word_t w;
    w.b0 = b0; w.b1 = b1; w.b2 = b2; w.len = len; w.last = 1'b0;
    return w;
  endfunction

  // works out the words caused by one accepted input word
  function automatic void predict_allocation();
    midi_word_t res[$];
    logic [7:0] note, vel;
    int ex, a;
    longint s, nn;
    case (cmd)
      CMD_MIDI: if (msg_len != 0) begin
        note = (msg_len >= 2) ? data1 : 8'd0;
        vel  = (msg_len >= 3) ? data2 : 8'd0;
        ex = voice_of(note);
        if (status_byte[7:4] == MSG_NOTE_ON && vel != 0) begin
          // re-struck note: release its voice first
          if (ex >= 0) begin
            res.push_back(mk({MSG_NOTE_OFF, chan_of(ex)}, {1'b0, voice_snd[ex]}, 8'd0,
                             LEN_FULL));
            voice_on[ex] = 1'b0;
            lru_free(ex);
          end
          a = lru_stack[0];
          if (voice_on[a]) begin
            res.push_back(mk({MSG_NOTE_OFF, chan_of(a)}, {1'b0, voice_snd[a]}, 8'd0,
                             LEN_FULL));
            steals++;
          end
          s = pitch_q16(note);
          nn = round_half_away(s, 65536);
          if (nn < 0) nn = 0;
          if (nn > 127) nn = 127;
          voice_src[a] = note;
          voice_snd[a] = nn[6:0];
          voice_bend[a] = bend_of(s, nn[6:0]);
          voice_on[a] = 1'b1;
          lru_pull(a);
          lru_stack[NCH - 1] = a;
          res.push_back(mk({MSG_BEND, chan_of(a)}, {1'b0, voice_bend[a][6:0]},
                           {1'b0, voice_bend[a][13:7]}, LEN_FULL));
          res.push_back(mk({MSG_NOTE_ON, chan_of(a)}, {1'b0, voice_snd[a]}, vel, LEN_FULL));
        end else if ((status_byte[7:4] == MSG_NOTE_OFF || status_byte[7:4] == MSG_NOTE_ON)
                     && ex >= 0) begin
          voice_on[ex] = 1'b0;
          lru_free(ex);
          res.push_back(mk({MSG_NOTE_OFF, chan_of(ex)}, {1'b0, voice_snd[ex]}, vel, LEN_FULL));
        end else begin
          res.push_back(mk(status_byte, note, vel, msg_len));   // pass-through
        end
      end
      CMD_TBL_WR: begin
        tuning[table_index] = table_value;
        tuning_written[table_index] = 1'b1;
        retune_voices();
      end
      CMD_RETUNE: retune_voices();
      default: if (bend_refresh) begin
        bend_refresh = 1'b0;
        for (int i = 0; i < NCH; i++)
          if (voice_on[i])
            res.push_back(mk({MSG_BEND, chan_of(i)}, {1'b0, voice_bend[i][6:0]},
                             {1'b0, voice_bend[i][13:7]}, LEN_FULL));
      end
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) expected_words.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------- checking
  always @(posedge clk) begin
    midi_word_t w;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $error("unexpected word %h %h %h len %0d", out_b0, out_b1, out_b2, out_len);
        errors++;
      end else begin
        w = expected_words.pop_front();
        if (out_b0 !== w.b0) begin
          $error("out_byte0 expected %h got %h", w.b0, out_b0); errors++;
        end
        if (out_b1 !== w.b1) begin
          $error("out_byte1 expected %h got %h", w.b1, out_b1); errors++;
        end
        if (out_b2 !== w.b2) begin
          $error("out_byte2 expected %h got %h", w.b2, out_b2); errors++;
        end
        if (out_len !== w.len) begin
          $error("out_length expected %0d got %0d", w.len, out_len); errors++;
        end
        if (out_last !== w.last) begin
          $error("last expected %0d got %0d", w.last, out_last); errors++;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- driving
  // one word: hold it until accepted, then maybe go idle
  task automatic send_word(cmd_e c, logic [7:0] st, logic [7:0] d1, logic [7:0] d2,
                           logic [1:0] len, logic [6:0] idx, logic [TBL_W-1:0] val);
    cmd <= c; status_byte <= st; data1 <= d1; data2 <= d2; msg_len <= len;
    table_index <= idx; table_value <= val;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    predict_allocation();
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  task automatic midi(logic [7:0] st, logic [7:0] d1, logic [7:0] d2, logic [1:0] len);
    send_word(CMD_MIDI, st, d1, d2, len, 7'($urandom), 21'($urandom));
  endtask

  task automatic table_write(logic [6:0] idx, logic [TBL_W-1:0] val);
    send_word(CMD_TBL_WR, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom), idx, val);
  endtask

  task automatic control(cmd_e c);
    send_word(c, 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom),
              7'($urandom), 21'($urandom));
  endtask

  // wait until every expected word has arrived and the block has gone quiet
  task automatic drain(bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || in_stall) @(posedge clk);
    if (settle) repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_span(logic [SPAN_W-1:0] v);
    drain(1'b1);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v >= 1 && v <= SPAN_MAX) span = v;   // out-of-range spans are dropped
  endtask

  // tuning near 12-tet with some detune, now and then anything at all
  function automatic logic [TBL_W-1:0] rand_tuning();
    int k;
    if ($urandom_range(9) == 0) return 21'($urandom);
    k = $urandom_range(0, 127);
    return 21'(526343 + (k - 60) * 5461 + int'($urandom_range(0, 8000)) - 4000);
  endfunction

  function automatic logic [7:0] pick_tuned_note();
    int idx;
    do idx = $urandom_range(0, 127); while (!tuning_written[idx]);
    return 8'(idx) | (($urandom_range(7) == 0) ? 8'h80 : 8'h00);
  endfunction

  // ---------------------------------------------------------------- tests
  task automatic test_passthrough();
    midi(8'h90, 8'd60, 8'd100, 2'd0);     // empty message, nothing comes out
    control(CMD_TICK);                    // tick with nothing pending
    midi(8'hF8, 8'hFF, 8'hFF, 2'd1);
    midi(8'hC3, 8'h85, 8'hFF, 2'd2);
    midi(8'hB0, 8'h07, 8'h7F, 2'd3);
    midi(8'h80, 8'd61, 8'd40, 2'd3);      // note-off for an untracked note
  endtask

  task automatic test_note_on_off();
    table_write(7'd60, 21'd526343);
    table_write(7'd69, 21'd526343 + 9 * 5461 + 1234);
    table_write(7'd1, 21'd0);             // far below the note range
    table_write(7'd2, 21'h1FFFFF);        // far above the note range
    midi(8'h90, 8'd60, 8'd100, 2'd3);
    midi(8'h91, 8'd60, 8'd255, 2'd3);     // re-struck note
    midi(8'h9F, 8'd1, 8'd1, 2'd3);
    midi(8'h90, 8'd2, 8'd127, 2'd3);
    midi(8'h90, 8'd188, 8'd64, 2'd3);     // note above 127 uses entry 60
    midi(8'h90, 8'd69, 8'd90, 2'd3);
    midi(8'h80, 8'd60, 8'd33, 2'd3);
    midi(8'h90, 8'd1, 8'd0, 2'd3);        // note-on with zero velocity frees
    midi(8'h90, 8'd2, 8'd55, 2'd2);       // short message, velocity counts as zero
  endtask

  task automatic test_retune_tick();
    table_write(7'd69, 21'd526343 + 9 * 5461 - 2000);
    control(CMD_RETUNE);
    control(CMD_TICK);
    control(CMD_TICK);                    // flag already cleared
  endtask

  task automatic test_random(int n, int idle, int stall, bit hold_off);
    int r;
    int v;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (hold_off && i % 40 == 39) drain(1'b0);
      r = $urandom_range(99);
      if (r < 40) begin
        midi({MSG_NOTE_ON, 4'($urandom)}, pick_tuned_note(), 8'($urandom_range(1, 255)),
             LEN_FULL);
      end else if (r < 60) begin
        v = $urandom_range(0, NCH - 1);
        if (voice_on[v])
          midi({($urandom_range(1) ? MSG_NOTE_OFF : MSG_NOTE_ON), 4'($urandom)},
               voice_src[v], ($urandom_range(1) ? 8'($urandom) : 8'd0), LEN_FULL);
        else
          midi({MSG_NOTE_OFF, 4'($urandom)}, 8'($urandom), 8'($urandom), LEN_FULL);
      end else if (r < 70) begin
        table_write(7'($urandom), rand_tuning());
      end else if (r < 75) begin
        control(CMD_RETUNE);
      end else if (r < 85) begin
        control(CMD_TICK);
      end else begin
        // anything else, lengths included; every entry is tuned by now
        midi(8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
      end
    end
  endtask

  // prefill so that every random note-on has a tuning entry to read
  task automatic fill_tuning();
    for (int k = 0; k < 128; k += 6) table_write(7'(k), rand_tuning());
  endtask

  initial begin
    span = SPAN_RST;
    bend_refresh = 1'b0;
    for (int i = 0; i < NCH; i++) begin
      voice_on[i] = 1'b0; voice_src[i] = '0; voice_snd[i] = '0; voice_bend[i] = '0;
      lru_stack[i] = i;
    end
    for (int i = 0; i < 128; i++) begin
      tuning[i] = '0;
      tuning_written[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_note_on_off();
    test_retune_tick();
    fill_tuning();
    // random words may strike any note, so tune every remaining entry now
    for (int k = 0; k < 128; k++)
      if (!tuning_written[k]) table_write(7'(k), rand_tuning());

    test_random(80, 0, 0, 1'b1);
    write_span(7'd1);
    test_random(75, 86, 0, 1'b0);
    write_span(7'd0);                     // ignored
    write_span(SPAN_MAX);
    test_random(75, 0, 86, 1'b0);
    write_span(7'd127);                   // ignored
    write_span(7'd12);
    test_random(75, 6, 6, 1'b0);

    drain(1'b1);
    $display("sent %0d words, checked %0d results, %0d voice steals",
             words_sent, words_seen, steals);
    $display("bend spans 48, 1, 96 and 12 with idle and stall phases");
    if (errors == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+hdl
hdl/mca_pkg.sv
hdl/mca_div.sv
hdl/mpe_channel_allocator.sv
bench/tb.sv
